FILE: design/fta_pkg.sv
// Shared constants, types and the quarter-wave sine table for the terrain altitude block.
package fta_pkg;

    // Sine table geometry
    localparam int SINE_ENTRIES = 1024;
    localparam int PHASE_W      = 10;
    localparam int QUARTER      = SINE_ENTRIES / 4;
    localparam int QIDX_W       = 9;
    localparam int MAG_W        = 31;
    localparam int NUM_TERMS    = 6;

    // Datapath widths
    localparam int TERM_W  = MAG_W + 2;
    localparam int PAIR_W  = TERM_W + 1;
    localparam int SUM_W   = PAIR_W + 2;
    localparam int FLOOR_SHIFT = 7;
    localparam int FL_W    = SUM_W - FLOOR_SHIFT;
    localparam int H_W     = 48;
    localparam int COORD_W = 10;

    typedef logic [PHASE_W-1:0]           phase_t;
    typedef logic [MAG_W-1:0]             mag_t;
    typedef logic signed [PAIR_W-1:0]     pair_t;
    typedef logic signed [FL_W-1:0]       fl_t;
    typedef logic signed [H_W-1:0]        height_t;
    typedef logic [QUARTER:0][MAG_W-1:0]  qtab_t;

    // Term coefficients, phase = a*x + b*z mod 1024
    localparam phase_t COEF_A [NUM_TERMS] = '{10'd1, 10'd4, 10'd1019, 10'd7, 10'd5, 10'd10};
    localparam phase_t COEF_B [NUM_TERMS] = '{10'd1022, 10'd3, 10'd3, 10'd5, 10'd11, 10'd7};
    // Weight 2 for terms one to four, 1 for five and six
    localparam logic WEIGHT_DBL [NUM_TERMS] = '{1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0};

    localparam logic [63:0] HALF_PI_Q62 = 64'h6487ED5110B4611A;
    localparam logic [63:0] STEP_Q62    = HALF_PI_Q62 / QUARTER;
    localparam logic [63:0] Q31_ONE     = 64'h7FFFFFFF;

    // (a * b) >> 62, truncated to 64 bits
    function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[125:62];
    endfunction

    // Taylor term divisor (2k)(2k+1)
    function automatic logic [63:0] taylor_div(input logic [63:0] v, input int k);
        logic [63:0] r;
        case (k)
            1:       r = v / 6;
            2:       r = v / 20;
            3:       r = v / 42;
            4:       r = v / 72;
            5:       r = v / 110;
            6:       r = v / 156;
            7:       r = v / 210;
            8:       r = v / 272;
            9:       r = v / 342;
            10:      r = v / 420;
            11:      r = v / 506;
            default: r = v / 600;
        endcase
        return r;
    endfunction

    // sin(theta) in Q62, theta in Q62 within [0, pi/2]
    function automatic logic [63:0] sin_q62(input logic [63:0] theta);
        logic [63:0] t2;
        logic [63:0] term;
        logic [63:0] acc;
        t2   = mul_q62(theta, theta);
        term = theta;
        acc  = theta;
        for (int k = 1; k <= 12; k++)
        begin
            term = taylor_div(mul_q62(term, t2), k);
            if (k % 2 == 1)
                acc = acc - term;
            else
                acc = acc + term;
        end
        return acc;
    endfunction

    // Quarter wave, entries 0..QUARTER, Q31 magnitude, rounded half up
    function automatic qtab_t build_qtab();
        qtab_t       tab;
        logic [63:0] s;
        logic [63:0] t;
        logic [63:0] v;
        for (int i = 0; i <= QUARTER; i++)
        begin
            s = sin_q62(STEP_Q62 * 64'(i));
            t = mul_q62(s, Q31_ONE << 8);
            v = (t + 64'd128) >> 8;
            if (v > Q31_ONE)
                v = Q31_ONE;
            tab[i] = v[MAG_W-1:0];
        end
        return tab;
    endfunction

    localparam qtab_t SINE_QTAB = build_qtab();

endpackage

FILE: design/fourier_terrain_altitude.sv
// Fourier terrain altitude: five-stage pipeline, mid height minus weighted sine sum over 128.
// Path: an accepted word passes the phase, sine, pair, total and output registers in turn.
// Throughput: one word per cycle while out_ready is high; every stage has its own valid bit
//   and loads when the next stage is empty or moving, so bubbles collapse under back-pressure.
// Reset: rst_n clears all valid bits and sets mid_height to 0; the sine table is constant.
module fourier_terrain_altitude (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic signed [fta_pkg::H_W-1:0] cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [fta_pkg::COORD_W-1:0]   tile_x,
    input  logic [fta_pkg::COORD_W-1:0]   tile_z,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [fta_pkg::H_W-1:0] height
);
    import fta_pkg::*;

    localparam height_t H_MAX = {1'b0, {(H_W-1){1'b1}}};
    localparam height_t H_MIN = {1'b1, {(H_W-1){1'b0}}};

    height_t mid_height_reg;
    logic    out_valid_reg;
    height_t height_reg;
    height_t height_next;

    logic    ph_valid;
    logic    ph_ready;
    phase_t  phase [NUM_TERMS];
    logic    sn_valid;
    logic    sn_ready;
    mag_t    mag   [NUM_TERMS];
    logic    neg   [NUM_TERMS];
    logic    fl_valid;
    logic    fl_ready;
    fl_t     fl;
    logic signed [H_W:0] diff;

    // Configuration register
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mid_height_reg <= '0;
        else if (cfg_valid)
            mid_height_reg <= cfg_data;
    end

    fta_phase u_phase (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (in_valid),
        .up_ready (in_ready),
        .tile_x   (tile_x),
        .tile_z   (tile_z),
        .dn_valid (ph_valid),
        .dn_ready (ph_ready),
        .phase    (phase)
    );

    fta_sine u_sine (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (ph_valid),
        .up_ready (ph_ready),
        .phase    (phase),
        .dn_valid (sn_valid),
        .dn_ready (sn_ready),
        .mag      (mag),
        .neg      (neg)
    );

    fta_accum u_accum (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (sn_valid),
        .up_ready (sn_ready),
        .mag      (mag),
        .neg      (neg),
        .dn_valid (fl_valid),
        .dn_ready (fl_ready),
        .fl       (fl)
    );

    // Output stage: subtract and saturate to 48 bits
    assign fl_ready = !out_valid_reg || out_ready;

    always_comb
    begin
        diff = (H_W+1)'(mid_height_reg) - (H_W+1)'(fl);
        if (diff[H_W] != diff[H_W-1])
            height_next = diff[H_W] ? H_MIN : H_MAX;
        else
            height_next = diff[H_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (fl_ready)
            out_valid_reg <= fl_valid;
    end

    always_ff @(posedge clk)
    begin
        if (fl_valid && fl_ready)
            height_reg <= height_next;
    end

    assign out_valid = out_valid_reg;
    assign height    = height_reg;

    // Input can only stall when a finished word is held at the output
    a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (out_valid && !out_ready))
        else $error("input stalled without output back-pressure");

    // Register write lands next cycle
    a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |=> (mid_height_reg == $past(cfg_data)))
        else $error("mid_height write lost");

    // With out_ready held high, an accepted word passes every stage register and is presented
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && out_ready) ##1 out_ready ##1 out_ready ##1 out_ready
        |=> ##1 out_valid)
        else $error("result missing after pipeline latency");

endmodule

FILE: design/fta_phase.sv
// Phase stage: six term phases from the tile coordinates.
module fta_phase (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          up_valid,
    output logic                          up_ready,
    input  logic [fta_pkg::COORD_W-1:0]   tile_x,
    input  logic [fta_pkg::COORD_W-1:0]   tile_z,
    output logic                          dn_valid,
    input  logic                          dn_ready,
    output fta_pkg::phase_t               phase [fta_pkg::NUM_TERMS]
);
    import fta_pkg::*;

    logic   valid_reg;
    phase_t phase_reg  [NUM_TERMS];
    phase_t phase_next [NUM_TERMS];
    logic   load;

    assign up_ready = !valid_reg || dn_ready;
    assign load     = up_valid && up_ready;

    // a*x + b*z, wrapping at 1024
    always_comb
    begin
        for (int i = 0; i < NUM_TERMS; i++)
            phase_next[i] = PHASE_W'(COEF_A[i] * phase_t'(tile_x))
                          + PHASE_W'(COEF_B[i] * phase_t'(tile_z));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (up_ready)
            valid_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            phase_reg <= phase_next;
    end

    assign dn_valid = valid_reg;
    assign phase    = phase_reg;

endmodule

FILE: design/fta_sine.sv
// Sine stage: quarter-wave table lookup for the six phases.
module fta_sine (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                up_valid,
    output logic                up_ready,
    input  fta_pkg::phase_t     phase [fta_pkg::NUM_TERMS],
    output logic                dn_valid,
    input  logic                dn_ready,
    output fta_pkg::mag_t       mag   [fta_pkg::NUM_TERMS],
    output logic                neg   [fta_pkg::NUM_TERMS]
);
    import fta_pkg::*;

    logic              valid_reg;
    mag_t              mag_reg  [NUM_TERMS];
    mag_t              mag_next [NUM_TERMS];
    logic              neg_reg  [NUM_TERMS];
    logic              neg_next [NUM_TERMS];
    logic [QIDX_W-1:0] qidx     [NUM_TERMS];
    logic              load;

    assign up_ready = !valid_reg || dn_ready;
    assign load     = up_valid && up_ready;

    // Odd quadrants read mirrored, upper half negates
    always_comb
    begin
        for (int i = 0; i < NUM_TERMS; i++)
        begin
            if (phase[i][PHASE_W-2])
                qidx[i] = QIDX_W'(QUARTER) - {1'b0, phase[i][PHASE_W-3:0]};
            else
                qidx[i] = {1'b0, phase[i][PHASE_W-3:0]};
            mag_next[i] = SINE_QTAB[qidx[i]];
            neg_next[i] = phase[i][PHASE_W-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (up_ready)
            valid_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            mag_reg <= mag_next;
            neg_reg <= neg_next;
        end
    end

    assign dn_valid = valid_reg;
    assign mag      = mag_reg;
    assign neg      = neg_reg;

endmodule

FILE: design/fta_accum.sv
// Accumulate stages: signed weighted pair sums, then total and floor shift by 7.
module fta_accum (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                up_valid,
    output logic                up_ready,
    input  fta_pkg::mag_t       mag [fta_pkg::NUM_TERMS],
    input  logic                neg [fta_pkg::NUM_TERMS],
    output logic                dn_valid,
    input  logic                dn_ready,
    output fta_pkg::fl_t        fl
);
    import fta_pkg::*;

    localparam int NUM_PAIRS = NUM_TERMS / 2;

    logic                     pair_valid_reg;
    logic                     sum_valid_reg;
    logic                     pair_ready;
    logic signed [TERM_W-1:0] term      [NUM_TERMS];
    pair_t                    pair_reg  [NUM_PAIRS];
    pair_t                    pair_next [NUM_PAIRS];
    logic signed [SUM_W-1:0]  total;
    fl_t                      fl_reg;
    fl_t                      fl_next;

    assign pair_ready = !sum_valid_reg || dn_ready;
    assign up_ready   = !pair_valid_reg || pair_ready;

    // Sign and weight each term, add neighbors
    always_comb
    begin
        for (int i = 0; i < NUM_TERMS; i++)
        begin
            term[i] = neg[i] ? -TERM_W'({1'b0, mag[i]}) : TERM_W'({1'b0, mag[i]});
            if (WEIGHT_DBL[i])
                term[i] = term[i] <<< 1;
        end
        for (int j = 0; j < NUM_PAIRS; j++)
            pair_next[j] = PAIR_W'(term[2*j]) + PAIR_W'(term[2*j+1]);
    end

    // Total, arithmetic shift is the floor of sum / 128
    always_comb
    begin
        total = SUM_W'(pair_reg[0]) + SUM_W'(pair_reg[1]) + SUM_W'(pair_reg[2]);
        fl_next = FL_W'(total >>> FLOOR_SHIFT);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pair_valid_reg <= 1'b0;
            sum_valid_reg  <= 1'b0;
        end
        else
        begin
            if (up_ready)
                pair_valid_reg <= up_valid;
            if (pair_ready)
                sum_valid_reg <= pair_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && up_ready)
            pair_reg <= pair_next;
        if (pair_valid_reg && pair_ready)
            fl_reg <= fl_next;
    end

    assign dn_valid = sum_valid_reg;
    assign fl       = fl_reg;

endmodule
